FILE: rtl/ptt_pkg.sv
// ptt_pkg: widths, word types, reject codes and limb helpers for the
// point-on-triangle test pipeline; no dependencies
package ptt_pkg;

    localparam int COORD_BITS = 24;
    localparam int TOL_BITS   = 23;

    // derived widths, all exact
    localparam int DW   = COORD_BITS + 1;   // vertex differences
    localparam int PW   = 2 * DW;           // coordinate products
    localparam int NW   = PW + 1;           // normal and cross terms
    localparam int NNW  = 2 * NW + 2;       // |n|^2
    localparam int DNW  = DW + NW + 2;      // d.n
    localparam int XW   = 2 * NW + 2;       // coefficient numerators
    localparam int D2W  = 2 * DNW;          // (d.n)^2
    localparam int T2W  = 2 * TOL_BITS;     // tol^2
    localparam int RW   = T2W + NNW + 1;    // tol^2 * |n|^2
    localparam int LW   = D2W + 2;          // 4 * (d.n)^2
    localparam int LIMB = 26;               // multiplier split
    localparam int PPW  = 2 * (LIMB + 1);   // partial product

    localparam int NSTAGE = 9;

    typedef logic signed [LIMB:0]  t_limb;
    typedef logic signed [PPW-1:0] t_pp;

    typedef enum logic [2:0] {
        CAUSE_INSIDE     = 3'd0,
        CAUSE_DEGENERATE = 3'd1,
        CAUSE_OFF_PLANE  = 3'd2,
        CAUSE_X_NEG      = 3'd3,
        CAUSE_Y_NEG      = 3'd4,
        CAUSE_SUM_ABOVE  = 3'd5
    } t_cause;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
        logic signed [COORD_BITS-1:0] pt_x;
        logic signed [COORD_BITS-1:0] pt_y;
        logic signed [COORD_BITS-1:0] pt_z;
    } t_in;

    typedef struct packed {
        logic   on_surface;
        t_cause reject_cause;
    } t_out;

    // unsigned low limb as a signed multiplier operand
    function automatic t_limb lo_limb(input logic [LIMB-1:0] v);
        return t_limb'({1'b0, v});
    endfunction

    function automatic t_pp pmul(input t_limb a, input t_limb b);
        return a * b;
    endfunction

endpackage

FILE: rtl/point_on_triangle_test.sv
// point_on_triangle_test: 3d point-on-triangle test with exact integer math
// depends on ptt_pkg
// datapath: the input word passes through the stage 1 to stage 8 registers into the registered result word
// throughput: one word per cycle; the whole pipeline holds on output stall
// reset: synchronous active low, clears all stage valids, tolerance to 1
module point_on_triangle_test import ptt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_in                 i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output t_out                o_out,
    input  logic                i_cfg_we,
    input  logic [TOL_BITS-1:0] i_cfg_data
);

    logic [NSTAGE-1:0]   r_vld;
    logic [TOL_BITS-1:0] r_tol;
    logic                en;

    assign en      = !(r_vld[NSTAGE-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_tol <= TOL_BITS'(1);
        end else begin
            if (en) begin
                r_vld <= {r_vld[NSTAGE-2:0], i_valid};
            end
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    // stage 1: edges and offset
    logic signed [COORD_BITS-1:0] va[3], vb[3], vc[3], vp[3];
    logic signed [DW-1:0] r1_u0[3], r1_u1[3], r1_d[3];

    assign va = '{i_in.a_x, i_in.a_y, i_in.a_z};
    assign vb = '{i_in.b_x, i_in.b_y, i_in.b_z};
    assign vc = '{i_in.c_x, i_in.c_y, i_in.c_z};
    assign vp = '{i_in.pt_x, i_in.pt_y, i_in.pt_z};

    // stage 2: normal products
    logic signed [PW-1:0] r2_p[6];
    logic signed [DW-1:0] r2_u0[3], r2_u1[3], r2_d[3];

    // stage 3: normal
    logic signed [NW-1:0] r3_n[3];
    logic signed [DW-1:0] r3_u0[3], r3_u1[3], r3_d[3];

    // stage 4: cross products and first partial products
    logic signed [PW-1:0] r4_tp[12];
    t_pp                  r4_dnl[3], r4_dnh[3];
    t_pp                  r4_nll[3], r4_nlh[3], r4_nhh[3];
    logic signed [NW-1:0] r4_n[3];
    logic                 r4_deg;

    // stage 5: sums
    logic signed [NW-1:0]  r5_tx[3], r5_ty[3], r5_n[3];
    logic signed [DNW-1:0] r5_dn;
    logic signed [NNW-1:0] r5_nn;
    logic                  r5_deg;
    logic signed [DNW-1:0] n_dn;
    logic signed [NNW-1:0] n_nn;

    // stage 6: second partial products
    t_pp                  r6_xp[3][4], r6_yp[3][4];
    t_pp                  r6_d00, r6_d01, r6_d02, r6_d11, r6_d12, r6_d22;
    logic [T2W-1:0]       r6_t2;
    logic signed [NNW-1:0] r6_nn;
    logic                  r6_deg;

    // stage 7
    logic signed [XW-1:0]  r7_xs, r7_ys;
    logic signed [D2W-1:0] r7_d2;
    t_pp                   r7_rp[2][4];
    logic signed [NNW-1:0] r7_nn;
    logic                  r7_deg;
    logic signed [XW-1:0]  n_xs, n_ys;
    logic signed [D2W-1:0] n_d2;

    // stage 8
    logic signed [LW-1:0]  r8_lhs;
    logic signed [RW-1:0]  r8_rhs;
    logic signed [XW:0]    r8_sum;
    logic                  r8_xneg, r8_yneg, r8_deg;
    logic signed [NNW-1:0] r8_nn;
    logic signed [RW-1:0]  n_rhs;

    t_limb n_lo[3], n_hi[3], d_l[3];
    t_limb t_lo[2][3], t_hi[2][3];
    t_limb dn_l0, dn_l1, dn_l2;
    t_limb t2_l[2], nn_l[4];
    t_out  n_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lo[k] = lo_limb(r3_n[k][LIMB-1:0]);
            n_hi[k] = t_limb'({{2{r3_n[k][NW-1]}}, r3_n[k][NW-1:LIMB]});
            d_l[k]  = t_limb'({{2{r3_d[k][DW-1]}}, r3_d[k]});
            t_lo[0][k] = lo_limb(r5_tx[k][LIMB-1:0]);
            t_hi[0][k] = t_limb'({{2{r5_tx[k][NW-1]}}, r5_tx[k][NW-1:LIMB]});
            t_lo[1][k] = lo_limb(r5_ty[k][LIMB-1:0]);
            t_hi[1][k] = t_limb'({{2{r5_ty[k][NW-1]}}, r5_ty[k][NW-1:LIMB]});
        end
        dn_l0 = lo_limb(r5_dn[LIMB-1:0]);
        dn_l1 = lo_limb(r5_dn[2*LIMB-1:LIMB]);
        dn_l2 = t_limb'({r5_dn[DNW-1], r5_dn[DNW-1:2*LIMB]});
        t2_l[0] = lo_limb(r6_t2[LIMB-1:0]);
        t2_l[1] = t_limb'({1'b0, {(2*LIMB-T2W){1'b0}}, r6_t2[T2W-1:LIMB]});
        nn_l[0] = lo_limb(r6_nn[LIMB-1:0]);
        nn_l[1] = lo_limb(r6_nn[2*LIMB-1:LIMB]);
        nn_l[2] = lo_limb(r6_nn[3*LIMB-1:2*LIMB]);
        nn_l[3] = t_limb'({r6_nn[NNW-1], r6_nn[NNW-1:3*LIMB]});
    end

    always_comb begin
        n_dn = '0;
        n_nn = '0;
        for (int k = 0; k < 3; k++) begin
            n_dn = n_dn + (DNW'(r4_dnh[k]) <<< LIMB) + DNW'(r4_dnl[k]);
            n_nn = n_nn + (NNW'(r4_nhh[k]) <<< (2*LIMB))
                        + (NNW'(r4_nlh[k]) <<< (LIMB+1)) + NNW'(r4_nll[k]);
        end
    end

    always_comb begin
        n_xs = '0;
        n_ys = '0;
        for (int k = 0; k < 3; k++) begin
            n_xs = n_xs + (XW'(r6_xp[k][3]) <<< (2*LIMB))
                 + ((XW'(r6_xp[k][1]) + XW'(r6_xp[k][2])) <<< LIMB) + XW'(r6_xp[k][0]);
            n_ys = n_ys + (XW'(r6_yp[k][3]) <<< (2*LIMB))
                 + ((XW'(r6_yp[k][1]) + XW'(r6_yp[k][2])) <<< LIMB) + XW'(r6_yp[k][0]);
        end
        n_d2 = (D2W'(r6_d22) <<< (4*LIMB)) + (D2W'(r6_d12) <<< (3*LIMB+1))
             + (((D2W'(r6_d02) <<< 1) + D2W'(r6_d11)) <<< (2*LIMB))
             + (D2W'(r6_d01) <<< (LIMB+1)) + D2W'(r6_d00);
    end

    always_comb begin
        n_rhs = '0;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_rhs = n_rhs + (RW'(r7_rp[i][j]) <<< ((i + j) * LIMB));
            end
        end
    end

    always_comb begin
        n_out.on_surface   = 1'b0;
        n_out.reject_cause = CAUSE_INSIDE;
        if (r8_deg) begin
            n_out.reject_cause = CAUSE_DEGENERATE;
        end else if (r8_lhs > LW'(r8_rhs)) begin
            n_out.reject_cause = CAUSE_OFF_PLANE;
        end else if (r8_xneg) begin
            n_out.reject_cause = CAUSE_X_NEG;
        end else if (r8_yneg) begin
            n_out.reject_cause = CAUSE_Y_NEG;
        end else if (r8_sum > (XW+1)'(r8_nn)) begin
            n_out.reject_cause = CAUSE_SUM_ABOVE;
        end else begin
            n_out.on_surface = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_u0[k] <= DW'(vb[k]) - DW'(va[k]);
                r1_u1[k] <= DW'(vc[k]) - DW'(va[k]);
                r1_d[k]  <= DW'(vp[k]) - DW'(va[k]);
            end
            r2_p[0] <= PW'(r1_u0[1]) * PW'(r1_u1[2]);
            r2_p[1] <= PW'(r1_u0[2]) * PW'(r1_u1[1]);
            r2_p[2] <= PW'(r1_u0[2]) * PW'(r1_u1[0]);
            r2_p[3] <= PW'(r1_u0[0]) * PW'(r1_u1[2]);
            r2_p[4] <= PW'(r1_u0[0]) * PW'(r1_u1[1]);
            r2_p[5] <= PW'(r1_u0[1]) * PW'(r1_u1[0]);
            r2_u0 <= r1_u0;
            r2_u1 <= r1_u1;
            r2_d  <= r1_d;

            for (int k = 0; k < 3; k++) begin
                r3_n[k] <= NW'(r2_p[2*k]) - NW'(r2_p[2*k+1]);
            end
            r3_u0 <= r2_u0;
            r3_u1 <= r2_u1;
            r3_d  <= r2_d;

            // d x u1 then u0 x d
            r4_tp[0]  <= PW'(r3_d[1]) * PW'(r3_u1[2]);
            r4_tp[1]  <= PW'(r3_d[2]) * PW'(r3_u1[1]);
            r4_tp[2]  <= PW'(r3_d[2]) * PW'(r3_u1[0]);
            r4_tp[3]  <= PW'(r3_d[0]) * PW'(r3_u1[2]);
            r4_tp[4]  <= PW'(r3_d[0]) * PW'(r3_u1[1]);
            r4_tp[5]  <= PW'(r3_d[1]) * PW'(r3_u1[0]);
            r4_tp[6]  <= PW'(r3_u0[1]) * PW'(r3_d[2]);
            r4_tp[7]  <= PW'(r3_u0[2]) * PW'(r3_d[1]);
            r4_tp[8]  <= PW'(r3_u0[2]) * PW'(r3_d[0]);
            r4_tp[9]  <= PW'(r3_u0[0]) * PW'(r3_d[2]);
            r4_tp[10] <= PW'(r3_u0[0]) * PW'(r3_d[1]);
            r4_tp[11] <= PW'(r3_u0[1]) * PW'(r3_d[0]);
            for (int k = 0; k < 3; k++) begin
                r4_dnl[k] <= pmul(d_l[k], n_lo[k]);
                r4_dnh[k] <= pmul(d_l[k], n_hi[k]);
                r4_nll[k] <= pmul(n_lo[k], n_lo[k]);
                r4_nlh[k] <= pmul(n_lo[k], n_hi[k]);
                r4_nhh[k] <= pmul(n_hi[k], n_hi[k]);
            end
            r4_n   <= r3_n;
            r4_deg <= (r3_n[0] == '0) && (r3_n[1] == '0) && (r3_n[2] == '0);

            for (int k = 0; k < 3; k++) begin
                r5_tx[k] <= NW'(r4_tp[2*k]) - NW'(r4_tp[2*k+1]);
                r5_ty[k] <= NW'(r4_tp[6+2*k]) - NW'(r4_tp[6+2*k+1]);
            end
            r5_n   <= r4_n;
            r5_dn  <= n_dn;
            r5_nn  <= n_nn;
            r5_deg <= r4_deg;

            // limb order: lo*lo, lo(t)*hi(n), hi(t)*lo(n), hi*hi
            for (int k = 0; k < 3; k++) begin
                r6_xp[k][0] <= pmul(t_lo[0][k], lo_limb(r5_n[k][LIMB-1:0]));
                r6_xp[k][1] <= pmul(t_lo[0][k],
                    t_limb'({{2{r5_n[k][NW-1]}}, r5_n[k][NW-1:LIMB]}));
                r6_xp[k][2] <= pmul(t_hi[0][k], lo_limb(r5_n[k][LIMB-1:0]));
                r6_xp[k][3] <= pmul(t_hi[0][k],
                    t_limb'({{2{r5_n[k][NW-1]}}, r5_n[k][NW-1:LIMB]}));
                r6_yp[k][0] <= pmul(t_lo[1][k], lo_limb(r5_n[k][LIMB-1:0]));
                r6_yp[k][1] <= pmul(t_lo[1][k],
                    t_limb'({{2{r5_n[k][NW-1]}}, r5_n[k][NW-1:LIMB]}));
                r6_yp[k][2] <= pmul(t_hi[1][k], lo_limb(r5_n[k][LIMB-1:0]));
                r6_yp[k][3] <= pmul(t_hi[1][k],
                    t_limb'({{2{r5_n[k][NW-1]}}, r5_n[k][NW-1:LIMB]}));
            end
            r6_d00 <= pmul(dn_l0, dn_l0);
            r6_d01 <= pmul(dn_l0, dn_l1);
            r6_d02 <= pmul(dn_l0, dn_l2);
            r6_d11 <= pmul(dn_l1, dn_l1);
            r6_d12 <= pmul(dn_l1, dn_l2);
            r6_d22 <= pmul(dn_l2, dn_l2);
            r6_t2  <= T2W'(r_tol) * T2W'(r_tol);
            r6_nn  <= r5_nn;
            r6_deg <= r5_deg;

            r7_xs <= n_xs;
            r7_ys <= n_ys;
            r7_d2 <= n_d2;
            for (int i = 0; i < 2; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r7_rp[i][j] <= pmul(t2_l[i], nn_l[j]);
                end
            end
            r7_nn  <= r6_nn;
            r7_deg <= r6_deg;

            r8_lhs  <= LW'(r7_d2) <<< 2;
            r8_rhs  <= n_rhs;
            r8_sum  <= (XW+1)'(r7_xs) + (XW+1)'(r7_ys);
            r8_xneg <= r7_xs[XW-1];
            r8_yneg <= r7_ys[XW-1];
            r8_nn   <= r7_nn;
            r8_deg  <= r7_deg;

            o_out <= n_out;
        end
    end

endmodule

FILE: rtl/ptt_check.sv
// ptt_check: port-level assertions for point_on_triangle_test, bound to it
// depends on ptt_pkg
module ptt_check import ptt_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input t_in                 i_in,
    input logic                o_valid,
    input logic                i_stall,
    input t_out                o_out,
    input logic                i_cfg_we,
    input logic [TOL_BITS-1:0] i_cfg_data
);

    // a held result word does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("output word changed under stall");

    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out.on_surface == (o_out.reject_cause == CAUSE_INSIDE))
        else $error("on_surface disagrees with reject_cause");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out.reject_cause <= CAUSE_SUM_ABOVE)
        else $error("reject code out of range");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

endmodule

bind point_on_triangle_test ptt_check u_ptt_check (.*);

FILE: dv/testbench.sv
// testbench for point_on_triangle_test: directed and random triangle/point words
// checked against an exact integer predictor; depends on ptt_pkg and the rtl
`timescale 1ns / 100ps

module testbench;
    import ptt_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    t_in                 i_in = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    t_out                o_out;
    logic                i_cfg_we = 1'b0;
    logic [TOL_BITS-1:0] i_cfg_data = '0;

    t_out               verdict_q[$];
    logic [TOL_BITS-1:0] tol_model = 1;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_cycles = 0;
    int  n_fail = 0;
    int  n_sent = 0;
    int  n_checked = 0;

    point_on_triangle_test DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef logic signed [127:0] t_big;

    function automatic t_out classify(t_in w, logic [TOL_BITS-1:0] tol);
        t_big u0[3], u1[3], d[3], n[3], t[3];
        t_big nn, dn, xs, ys;
        t_out r;
        u0[0] = t_big'(w.b_x) - t_big'(w.a_x);
        u0[1] = t_big'(w.b_y) - t_big'(w.a_y);
        u0[2] = t_big'(w.b_z) - t_big'(w.a_z);
        u1[0] = t_big'(w.c_x) - t_big'(w.a_x);
        u1[1] = t_big'(w.c_y) - t_big'(w.a_y);
        u1[2] = t_big'(w.c_z) - t_big'(w.a_z);
        d[0]  = t_big'(w.pt_x) - t_big'(w.a_x);
        d[1]  = t_big'(w.pt_y) - t_big'(w.a_y);
        d[2]  = t_big'(w.pt_z) - t_big'(w.a_z);
        n[0] = u0[1] * u1[2] - u0[2] * u1[1];
        n[1] = u0[2] * u1[0] - u0[0] * u1[2];
        n[2] = u0[0] * u1[1] - u0[1] * u1[0];
        nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
        r.on_surface = 1'b0;
        if (nn == 0) begin
            r.reject_cause = CAUSE_DEGENERATE;
            return r;
        end
        dn = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
        // (d.n)^2 can reach ~2^150, so compare in 256 bits
        t[0] = d[1] * u1[2] - d[2] * u1[1];
        t[1] = d[2] * u1[0] - d[0] * u1[2];
        t[2] = d[0] * u1[1] - d[1] * u1[0];
        xs = t[0] * n[0] + t[1] * n[1] + t[2] * n[2];
        t[0] = u0[1] * d[2] - u0[2] * d[1];
        t[1] = u0[2] * d[0] - u0[0] * d[2];
        t[2] = u0[0] * d[1] - u0[1] * d[0];
        ys = t[0] * n[0] + t[1] * n[1] + t[2] * n[2];
        begin
            logic signed [255:0] l2, r2;
            l2 = 256'(4) * 256'(dn) * 256'(dn);
            r2 = 256'(tol) * 256'(tol) * 256'(nn);
            if (l2 > r2)              r.reject_cause = CAUSE_OFF_PLANE;
            else if (xs < 0)          r.reject_cause = CAUSE_X_NEG;
            else if (ys < 0)          r.reject_cause = CAUSE_Y_NEG;
            else if (xs + ys > nn)    r.reject_cause = CAUSE_SUM_ABOVE;
            else                      r.reject_cause = CAUSE_INSIDE;
        end
        r.on_surface = (r.reject_cause == CAUSE_INSIDE);
        return r;
    endfunction

    // receiver side: random stall plus long hold-offs, and the result checker
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                $error("result word with nothing expected");
                n_fail++;
            end else begin
                t_out e;
                e = verdict_q.pop_front();
                if (o_out.on_surface !== e.on_surface) begin
                    $error("on_surface expected %0d actual %0d", e.on_surface, o_out.on_surface);
                    n_fail++;
                end
                if (o_out.reject_cause !== e.reject_cause) begin
                    $error("reject_cause expected %0d actual %0d",
                           e.reject_cause, o_out.reject_cause);
                    n_fail++;
                end
                n_checked++;
            end
        end
    end

    // valid stays up after an accept until the next word or an idle cycle
    task automatic send_word(t_in w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in    <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        verdict_q.insert(verdict_q.size(), classify(w, tol_model));
        n_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (NSTAGE + 4) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOL_BITS-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tol_model = v;
    endtask

    function automatic logic signed [23:0] rnd_coord(int span);
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
            default: return 24'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    function automatic t_in mk(int ax, int ay, int az, int bx, int by, int bz,
                               int cx, int cy, int cz, int px, int py, int pz);
        t_in w;
        w = {24'(ax), 24'(ay), 24'(az), 24'(bx), 24'(by), 24'(bz),
             24'(cx), 24'(cy), 24'(cz), 24'(px), 24'(py), 24'(pz)};
        return w;
    endfunction

    // point built from the triangle: a + (s*u0 + t*u1)/12 plus a random offset of -2..2 per axis
    function automatic t_in rnd_on_triangle();
        int ax, ay, az, s, t, bx, by, bz, cx, cy, cz;
        int m;
        t_in w;
        m = $urandom_range(4) == 0 ? 4000000 : 2000;
        ax = $signed($urandom_range(2 * m)) - m;
        ay = $signed($urandom_range(2 * m)) - m;
        az = $signed($urandom_range(2 * m)) - m;
        bx = $signed($urandom_range(2 * m)) - m; by = $signed($urandom_range(2 * m)) - m;
        bz = $signed($urandom_range(2 * m)) - m;
        cx = $signed($urandom_range(2 * m)) - m; cy = $signed($urandom_range(2 * m)) - m;
        cz = $signed($urandom_range(2 * m)) - m;
        s = $urandom_range(12);
        t = $urandom_range(12 - s + ($urandom_range(3) == 0 ? 2 : 0));
        if ($urandom_range(5) == 0) s = -1;
        w = mk(ax, ay, az, bx, by, bz, cx, cy, cz, 0, 0, 0);
        w.pt_x = 24'(ax + (s * (bx - ax) + t * (cx - ax)) / 12 + $signed($urandom_range(4)) - 2);
        w.pt_y = 24'(ay + (s * (by - ay) + t * (cy - ay)) / 12 + $signed($urandom_range(4)) - 2);
        w.pt_z = 24'(az + (s * (bz - az) + t * (cz - az)) / 12 + $signed($urandom_range(4)) - 2);
        return w;
    endfunction

    task automatic test_directed();
        send_word(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 0));       // inside
        send_word(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0));         // vertex
        send_word(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 128, 128, 0));     // on hypotenuse
        send_word(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 129, 128, 0));     // sum above
        send_word(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, -1, 10, 0));       // first neg
        send_word(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 10, -1, 0));       // second neg
        send_word(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 10, 10, 1));       // off plane by 1
        send_word(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, -5, -5, 9));       // several failures
        send_word(mk(1, 2, 3, 1, 2, 3, 7, 8, 9, 1, 2, 3));             // repeated vertex
        send_word(mk(0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 1, 1));             // collinear
        send_word(mk(-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
                     -8388608, 8388607, -8388608, 0, 0, -8388608));
        send_word(mk(8388607, 8388607, 8388607, -8388608, 8388607, 8388607,
                     8388607, -8388608, -8388608, 8388607, -8388608, 8388607));
        send_word(mk(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                     -8388608, -8388608, 8388607, -8388608, 8388607, -8388608));
        send_word(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    endtask

    task automatic test_random(int count);
        t_in w;
        repeat (count) begin
            if ($urandom_range(9) < 7) begin
                w = rnd_on_triangle();
            end else begin
                w = {rnd_coord(600), rnd_coord(600), rnd_coord(600), rnd_coord(600),
                     rnd_coord(600), rnd_coord(600), rnd_coord(600), rnd_coord(600),
                     rnd_coord(600), rnd_coord(600), rnd_coord(600), rnd_coord(600)};
            end
            send_word(w);
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 60;
        test_random(40);
        drain();          // sender pause until every result is back
        test_random(20);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_tolerance(0);
        test_directed();
        write_tolerance(23'h7fffff);
        test_directed();
        write_tolerance(16);
        send_idle_pct = 34; recv_idle_pct = 59;
        test_random(400);
        write_tolerance(23'($urandom));
        send_idle_pct = 59; recv_idle_pct = 34;
        test_random(400);
        write_tolerance(3);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(300);
        test_backpressure();
        drain();
        $display("covered %0d words, %0d results checked, tolerances 0..max, stalls",
                 n_sent, n_checked);
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
